// ----- rtl/jobs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the JSON object boundary scanner.
// Used by the result interface, the top level and the bench; depends on nothing.
package jobs_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int DEPTH_BITS_DEFAULT    = 8;

  localparam int START_W  = 16;
  localparam int LENGTH_W = 17;

  localparam logic [LENGTH_W-1:0] MAX_OBJECT_LEN_RESET = 17'd4096;

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    ST_FOUND        = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_UNTERMINATED = 3'd2,
    ST_NO_BRACE     = 3'd3,
    ST_OVERFLOW     = 3'd4
  } scan_status_t;

  typedef enum logic [2:0] {
    PH_SEEK = 3'b001,
    PH_IN   = 3'b010,
    PH_DONE = 3'b100
  } scan_phase_t;

endpackage

// ----- rtl/jobs_in_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one text byte or a terminator per beat.
// Depends on nothing beyond the handshake signals it declares.
interface jobs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- rtl/jobs_out_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one scan result per beat.
// Depends on jobs_pkg for the status type and field widths.
interface jobs_out_if;
  logic                           valid;
  logic                           ready;
  jobs_pkg::scan_status_t         scan_status;
  logic [jobs_pkg::START_W-1:0]   object_start;
  logic [jobs_pkg::LENGTH_W-1:0]  object_length;

  modport source (output valid, output scan_status, output object_start,
                  output object_length, input ready);
  modport sink   (input valid, input scan_status, input object_start,
                  input object_length, output ready);
endinterface

// ----- rtl/json_object_boundary_scanner_top.sv -----
`timescale 1ns / 1ps
// JSON object boundary scanner: finds the first brace-delimited object in a byte stream.
// Depends on jobs_pkg, jobs_in_if and jobs_out_if.
//
// Usage: feed a text one byte per beat on the text channel and close it with a
// beat that has end_of_text set. Every text yields exactly one beat on the
// result channel: found or too large on the closing brace itself, nesting
// overflow on the brace past the deepest nesting, unterminated or no brace on
// the terminator. Other beats yield nothing.
// The user must write the limit max_object_len through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this. It resets to 4096.
// Throughput is one beat per cycle while a held result does not stall it. A beat
// is held in the input register, is processed there by the scan logic, and its
// result is registered in the output register.
// When the receiver stalls, the held result blocks only a later beat that also
// produces a result; beats that produce none keep flowing.
// Synchronous reset clears both registers and the scan state and starts a new
// text; a partly received text is dropped.
module json_object_boundary_scanner_top #(
  parameter int POSITION_BITS = jobs_pkg::POSITION_BITS_DEFAULT,
  parameter int DEPTH_BITS    = jobs_pkg::DEPTH_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [jobs_pkg::LENGTH_W-1:0] cfg_wdata,
  jobs_in_if.sink                       text,
  jobs_out_if.source                    result
);
  import jobs_pkg::*;

  // Wide enough for a position plus one and for the configured limit.
  localparam int LW = (POSITION_BITS + 1 > LENGTH_W) ? POSITION_BITS + 1 : LENGTH_W;
  typedef logic [LW-1:0] len_w_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX = '1;

  logic [LENGTH_W-1:0] max_object_len;

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end;

  // Scan state.
  scan_phase_t             phase, phase_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] start_position, start_position_next;
  logic [DEPTH_BITS-1:0]    nesting_depth, nesting_depth_next;
  logic                     inside_string, inside_string_next;
  logic                     after_backslash, after_backslash_next;

  // Result of the beat in the input register.
  logic                has_result;
  scan_status_t        res_status;
  logic [START_W-1:0]  res_start;
  logic [LENGTH_W-1:0] res_length;

  logic   fire;
  len_w_t obj_len;
  len_w_t start_ext;

  assign obj_len   = len_w_t'(byte_position) - len_w_t'(start_position) + len_w_t'(1);
  assign start_ext = len_w_t'(start_position);

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    start_position_next  = start_position;
    nesting_depth_next   = nesting_depth;
    inside_string_next   = inside_string;
    after_backslash_next = after_backslash;
    has_result           = 1'b0;
    res_status           = ST_FOUND;
    res_start            = start_ext[START_W-1:0];
    res_length           = '0;

    if (in_end) begin
      if (phase == PH_SEEK) begin
        has_result = 1'b1;
        res_status = ST_NO_BRACE;
        res_start  = '0;
      end else if (phase == PH_IN) begin
        has_result = 1'b1;
        res_status = ST_UNTERMINATED;
      end
      phase_next           = PH_SEEK;
      byte_position_next   = '0;
      start_position_next  = '0;
      nesting_depth_next   = '0;
      inside_string_next   = 1'b0;
      after_backslash_next = 1'b0;
    end else begin
      case (phase)
        PH_SEEK: begin
          if (in_byte == CH_OPEN) begin
            start_position_next  = byte_position;
            nesting_depth_next   = DEPTH_BITS'(1);
            inside_string_next   = 1'b0;
            after_backslash_next = 1'b0;
            phase_next           = PH_IN;
          end
        end
        PH_IN: begin
          if (inside_string) begin
            if (after_backslash) begin
              after_backslash_next = 1'b0;
            end else if (in_byte == CH_BSLASH) begin
              after_backslash_next = 1'b1;
            end else if (in_byte == CH_QUOTE) begin
              inside_string_next = 1'b0;
            end
          end else if (in_byte == CH_QUOTE) begin
            inside_string_next = 1'b1;
          end else if (in_byte == CH_OPEN) begin
            if (nesting_depth == DEPTH_MAX) begin
              has_result = 1'b1;
              res_status = ST_OVERFLOW;
              phase_next = PH_DONE;
            end else begin
              nesting_depth_next = nesting_depth + DEPTH_BITS'(1);
            end
          end else if (in_byte == CH_CLOSE) begin
            // The closing brace at depth one (or a stray one at depth zero) ends the object.
            if (nesting_depth <= DEPTH_BITS'(1)) begin
              nesting_depth_next = '0;
              has_result         = 1'b1;
              res_status         = (obj_len > len_w_t'(max_object_len)) ? ST_TOO_LARGE
                                                                         : ST_FOUND;
              res_length         = obj_len[LENGTH_W-1:0];
              phase_next         = PH_DONE;
            end else begin
              nesting_depth_next = nesting_depth - DEPTH_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
      if (byte_position != POS_MAX) begin
        byte_position_next = byte_position + POSITION_BITS'(1);
      end
    end
  end

  // The held beat retires unless it has a result and the output slot is stuck.
  assign fire       = in_full && (!has_result || !result.valid || result.ready);
  assign text.ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_object_len <= MAX_OBJECT_LEN_RESET;
    end else if (cfg_we) begin
      max_object_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text.ready) begin
      in_full <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.text_byte;
      in_end  <= text.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEEK;
      byte_position   <= '0;
      start_position  <= '0;
      nesting_depth   <= '0;
      inside_string   <= 1'b0;
      after_backslash <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      start_position  <= start_position_next;
      nesting_depth   <= nesting_depth_next;
      inside_string   <= inside_string_next;
      after_backslash <= after_backslash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire && has_result) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      result.scan_status   <= res_status;
      result.object_start  <= res_start;
      result.object_length <= res_length;
    end
  end

endmodule

// ----- dv/json_object_boundary_scanner_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for json_object_boundary_scanner_top: directed and random texts are
// scored against a brace and string tracking scan kept inside the bench.
// Depends on jobs_pkg, jobs_in_if, jobs_out_if and the scanner RTL.
module json_object_boundary_scanner_top_tb;
  import jobs_pkg::*;

  localparam int POSITION_BITS = POSITION_BITS_DEFAULT;
  localparam int DEPTH_BITS    = DEPTH_BITS_DEFAULT;
  localparam logic [START_W-1:0]    POS_LIMIT   = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_LIMIT = '1;
  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int BEATS_PER_PHASE  = 50;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_beat_t;

  typedef struct packed {
    scan_status_t          status;
    logic [START_W-1:0]    start;
    logic [LENGTH_W-1:0]   length;
  } scan_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [LENGTH_W-1:0] cfg_wdata;

  jobs_in_if  text_ch ();
  jobs_out_if result_ch ();

  json_object_boundary_scanner_top #(
    .POSITION_BITS(POSITION_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .text(text_ch),
    .result(result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_beat_t   text_beats[$];
  scan_result_t results_due[$];
  int gap_pct;
  int stall_pct;
  int mismatches = 0;
  int cycle_count = 0;
  int queued_beats = 0;

  // Bench copy of the scan state and of the length limit.
  logic [LENGTH_W-1:0]   limit_len;
  scan_phase_t           scan_state;
  logic [START_W-1:0]    next_pos;
  logic [START_W-1:0]    brace_pos;
  logic [DEPTH_BITS-1:0] depth;
  logic                  quoted;
  logic                  escaped;

  task automatic clear_scan();
    scan_state = PH_SEEK;
    next_pos   = '0;
    brace_pos  = '0;
    depth      = '0;
    quoted     = 1'b0;
    escaped    = 1'b0;
  endtask

  task automatic push_expected(input scan_status_t status, input logic [START_W-1:0] start,
                               input logic [LENGTH_W-1:0] length);
    scan_result_t r;
    r.status = status;
    r.start  = start;
    r.length = length;
    results_due.push_back(r);
  endtask

  task automatic scan_beat(input logic [7:0] b, input logic eot);
    logic [LENGTH_W-1:0] span;
    if (eot) begin
      if (scan_state == PH_SEEK) begin
        push_expected(ST_NO_BRACE, '0, '0);
      end else if (scan_state == PH_IN) begin
        push_expected(ST_UNTERMINATED, brace_pos, '0);
      end
      clear_scan();
    end else begin
      case (scan_state)
        PH_SEEK: begin
          if (b == CH_OPEN) begin
            brace_pos  = next_pos;
            depth      = DEPTH_BITS'(1);
            quoted     = 1'b0;
            escaped    = 1'b0;
            scan_state = PH_IN;
          end
        end
        PH_IN: begin
          if (quoted) begin
            if (escaped) escaped = 1'b0;
            else if (b == CH_BSLASH) escaped = 1'b1;
            else if (b == CH_QUOTE) quoted = 1'b0;
          end else if (b == CH_QUOTE) begin
            quoted = 1'b1;
          end else if (b == CH_OPEN) begin
            if (depth == DEPTH_LIMIT) begin
              push_expected(ST_OVERFLOW, brace_pos, '0);
              scan_state = PH_DONE;
            end else begin
              depth = depth + 1'b1;
            end
          end else if (b == CH_CLOSE) begin
            if (depth != 0) depth = depth - 1'b1;
            if (depth == 0) begin
              span = {1'b0, next_pos} - {1'b0, brace_pos} + 1'b1;
              push_expected((span > limit_len) ? ST_TOO_LARGE : ST_FOUND, brace_pos, span);
              scan_state = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
      // The offset counter sticks at its top value.
      if (next_pos != POS_LIMIT) next_pos = next_pos + 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // Stimulus helpers: each appends beats to the pending queue.
  task automatic push_char(input logic [7:0] b);
    text_beat_t beat;
    beat.text_byte   = b;
    beat.end_of_text = 1'b0;
    text_beats.push_back(beat);
    queued_beats++;
  endtask

  task automatic push_end();
    text_beat_t beat;
    beat.text_byte   = 8'($urandom_range(255));
    beat.end_of_text = 1'b1;
    text_beats.push_back(beat);
    queued_beats++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_letters(input int n);
    for (int i = 0; i < n; i++) push_char(8'($urandom_range(8'h61, 8'h7A)));
  endtask

  task automatic push_noise(input int n, input bit no_open);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(255)); while (no_open && b == CH_OPEN);
      push_char(b);
    end
  endtask

  task automatic push_string();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    push_char(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          push_char(CH_BSLASH);
          push_char(8'($urandom_range(255)));
        end
        1: push_char($urandom_range(1) ? CH_OPEN : CH_CLOSE);
        default: begin
          do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
          push_char(b);
        end
      endcase
    end
    push_char(CH_QUOTE);
  endtask

  task automatic push_object(input int depth_left);
    int members;
    members = $urandom_range(0, 4);
    push_char(CH_OPEN);
    for (int i = 0; i < members; i++) begin
      case ($urandom_range(3))
        0: push_string();
        1: begin
          if (depth_left > 0) push_object(depth_left - 1);
          else push_letters(2);
        end
        default: begin
          push_letters($urandom_range(1, 4));
          push_text(":");
          push_noise($urandom_range(0, 2), 1'b0);
          push_text(",");
        end
      endcase
    end
    push_char(CH_CLOSE);
  endtask

  task automatic push_random_text();
    int kind;
    int mark;
    int drop;
    kind = $urandom_range(99);
    if (kind < 60) begin
      push_noise($urandom_range(0, 6), 1'b1);
      push_object($urandom_range(0, 3));
      push_noise($urandom_range(0, 5), 1'b0);
    end else if (kind < 72) begin
      // Object cut short before its closing brace; the opening brace always stays.
      push_noise($urandom_range(0, 4), 1'b1);
      mark = queued_beats;
      push_object($urandom_range(1, 3));
      drop = $urandom_range(1, 3);
      if (drop > queued_beats - mark - 1) drop = queued_beats - mark - 1;
      repeat (drop) begin
        void'(text_beats.pop_back());
        queued_beats--;
      end
    end else if (kind < 82) begin
      push_noise($urandom_range(0, 10), 1'b1);
    end else if (kind < 88) begin
      // Empty text: terminator only.
    end else if (kind < 99) begin
      push_noise($urandom_range(0, 20), 1'b0);
    end else begin
      drop = $urandom_range(int'(DEPTH_LIMIT) - 5, int'(DEPTH_LIMIT) + 3);
      repeat (drop) push_char(CH_OPEN);
      repeat (drop) push_char(CH_CLOSE);
    end
    push_end();
  endtask

  // Waits until every beat is taken and every result has come, then lets
  // the pipeline settle so a beat without a result cannot still be inside.
  task automatic wait_idle();
    while (text_beats.size() != 0 || text_ch.valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LENGTH_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_len = value;
  endtask

  task automatic run_random_phase(input logic [LENGTH_W-1:0] value, input int gap,
                                  input int stall);
    int mark;
    write_limit(value);
    gap_pct   <= gap;
    stall_pct <= stall;
    mark = queued_beats;
    while (queued_beats - mark < BEATS_PER_PHASE) push_random_text();
  endtask

  // Driver: presents pending beats and updates the predicted scan on each accepted one.
  always @(posedge clk) begin
    text_beat_t beat;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) scan_beat(text_ch.text_byte, text_ch.end_of_text);
      if (!text_ch.valid || text_ch.ready) begin
        if (text_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
          beat = text_beats.pop_front();
          text_ch.valid       <= 1'b1;
          text_ch.text_byte   <= beat.text_byte;
          text_ch.end_of_text <= beat.end_of_text;
        end else begin
          text_ch.valid     <= 1'b0;
          text_ch.text_byte <= 8'($urandom_range(255));
        end
      end
    end
  end

  // Monitor: each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result: status %0d start %0d length %0d",
                                  result_ch.scan_status, result_ch.object_start,
                                  result_ch.object_length));
        end else begin
          want = results_due.pop_front();
          if (result_ch.scan_status !== want.status || result_ch.object_start !== want.start ||
              result_ch.object_length !== want.length) begin
            note_mismatch($sformatf(
              "expected status %0d start %0d length %0d, got status %0d start %0d length %0d",
              want.status, want.start, want.length, result_ch.scan_status,
              result_ch.object_start, result_ch.object_length));
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = '0;
    text_ch.end_of_text = 1'b0;
    result_ch.ready     = 1'b0;
    gap_pct             = 21;
    stall_pct           = 86;
    limit_len           = MAX_OBJECT_LEN_RESET;
    clear_scan();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed texts under the reset limit.
    push_end();
    push_text("{}");
    push_end();
    // A quote ahead of the first brace is ignored; the brace inside the string is not counted.
    push_text("a\"{\"}\"}");
    push_end();
    // Escaped quote and escaped backslash in a string, then trailing bytes after the object.
    push_text("{\"\\\"{\\\\\"}");
    push_char(CH_OPEN);
    push_char(8'hFF);
    push_char(8'h00);
    push_char(CH_CLOSE);
    push_end();
    push_char(8'h00);
    push_char(8'hFF);
    push_text("}\"");
    push_end();
    push_text("x{{}");
    push_end();
    // One brace past the deepest nesting the counter holds, then the deepest that fits.
    repeat (int'(DEPTH_LIMIT) + 1) push_char(CH_OPEN);
    push_char(CH_CLOSE);
    push_end();
    repeat (int'(DEPTH_LIMIT)) push_char(CH_OPEN);
    repeat (int'(DEPTH_LIMIT)) push_char(CH_CLOSE);
    push_end();

    run_random_phase(17'd0, 21, 86);
    run_random_phase(17'd1, 21, 86);
    run_random_phase(17'd12, 86, 21);
    run_random_phase(17'd65536, 86, 21);
    run_random_phase(LENGTH_W'($urandom_range(2, 40)), 0, 0);

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
